/* rtl/assert_macros.svh */
// Assertion macros shared by the block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define SEE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define SEE_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/see_pkg.sv */
package see_pkg;

    localparam int RUN_BYTES = 4;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [1:0]                  last_idx;
        logic [RUN_BYTES-1:0][7:0]   seq;
        logic                        text_end;
    } t_run;

endpackage

/* rtl/see_front.sv */
module see_front (
    input  logic          i_in_valid,
    input  see_pkg::t_byte i_in_byte,
    input  logic          i_text_end,
    output logic          o_in_stall,
    output logic          o_push,
    output see_pkg::t_run o_run,
    input  logic          i_full
);
    import see_pkg::*;

    localparam t_byte C_QUOTE     = 8'h22;
    localparam t_byte C_BACKSLASH = 8'h5C;
    localparam t_byte C_LF        = 8'h0A;
    localparam t_byte C_CR        = 8'h0D;
    localparam t_byte C_TAB       = 8'h09;
    localparam t_byte C_VT        = 8'h0B;
    localparam t_byte C_FF        = 8'h0C;
    localparam t_byte C_SPACE     = 8'h20;
    localparam t_byte C_CHAR_X    = 8'h78;
    localparam t_byte C_CHAR_N    = 8'h6E;
    localparam t_byte C_CHAR_R    = 8'h72;
    localparam t_byte C_CHAR_T    = 8'h74;
    localparam t_byte C_CHAR_V    = 8'h76;
    localparam t_byte C_CHAR_F    = 8'h66;
    localparam t_byte C_DIGIT_0   = 8'h30;
    localparam t_byte C_LOWER_A   = 8'h61;

    function automatic t_byte hex_digit(input logic [3:0] v);
        t_byte wide;
        wide = {4'h0, v};
        if (v < 4'd10) begin
            return C_DIGIT_0 + wide;
        end
        return C_LOWER_A + wide - 8'd10;
    endfunction

    t_run run;

    always_comb begin
        run          = '0;
        run.text_end = i_text_end;
        run.seq[0]   = C_BACKSLASH;
        run.last_idx = 2'd1;
        case (i_in_byte)
            C_QUOTE, C_BACKSLASH: run.seq[1] = i_in_byte;
            C_LF: run.seq[1] = C_CHAR_N;
            C_CR: run.seq[1] = C_CHAR_R;
            C_TAB: run.seq[1] = C_CHAR_T;
            C_VT: run.seq[1] = C_CHAR_V;
            C_FF: run.seq[1] = C_CHAR_F;
            default: begin
                if (i_in_byte < C_SPACE) begin
                    run.seq[1]   = C_CHAR_X;
                    run.seq[2]   = hex_digit(i_in_byte[7:4]);
                    run.seq[3]   = hex_digit(i_in_byte[3:0]);
                    run.last_idx = 2'd3;
                end else begin
                    run.seq[0]   = i_in_byte;
                    run.last_idx = 2'd0;
                end
            end
        endcase
    end

    assign o_run      = run;
    assign o_push     = i_in_valid;
    assign o_in_stall = i_full;

endmodule

/* rtl/see_fifo.sv */
`include "assert_macros.svh"

module see_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `SEE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue count overflow")
    `SEE_ASSERT(a_empty_ptrs, i_clk, i_rst_n, (r_count == '0) |-> (r_wr_ptr == r_rd_ptr), "empty queue with unequal pointers")
    `SEE_ASSERT(a_push_grows, i_clk, i_rst_n, (do_push && !do_pop) |=> (r_count == CNT_W'($past(r_count) + 1'b1)), "accepted item not counted")

endmodule

/* rtl/see_back.sv */
`include "assert_macros.svh"

module see_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  see_pkg::t_run  i_head,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output see_pkg::t_byte o_out_byte,
    output logic           o_run_last,
    output logic           o_text_done
);
    import see_pkg::*;

    logic       r_busy, n_busy;
    t_run       r_run, n_run;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_byte      r_out_byte, n_out_byte;
    logic       r_run_last, n_run_last;
    logic       r_text_done, n_text_done;
    logic       out_free;
    logic       last;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_busy      = r_busy;
        n_run       = r_run;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_run_last  = r_run_last;
        n_text_done = r_text_done;
        o_pop       = 1'b0;
        last        = 1'b0;
        if (out_free) begin
            n_out_valid = 1'b0;
            if (r_busy) begin
                last        = (r_idx == r_run.last_idx);
                n_out_byte  = r_run.seq[r_idx];
                n_run_last  = last;
                n_text_done = last && r_run.text_end;
                n_out_valid = 1'b1;
                n_idx       = 2'(r_idx + 2'd1);
                n_busy      = !last;
            end else if (!i_empty) begin
                last        = (i_head.last_idx == 2'd0);
                o_pop       = 1'b1;
                n_run       = i_head;
                n_idx       = 2'd1;
                n_out_byte  = i_head.seq[0];
                n_run_last  = last;
                n_text_done = last && i_head.text_end;
                n_out_valid = 1'b1;
                n_busy      = !last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run       <= n_run;
        r_idx       <= n_idx;
        r_out_byte  <= n_out_byte;
        r_run_last  <= n_run_last;
        r_text_done <= n_text_done;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_text_done = r_text_done;

    `SEE_ASSERT(a_idx_range, i_clk, i_rst_n, r_busy |-> ((r_idx != 2'd0) && (r_idx <= r_run.last_idx)), "run index out of range")
    `SEE_ASSERT(a_done_on_last, i_clk, i_rst_n, (r_out_valid && r_text_done) |-> r_run_last, "end of text away from end of run")
    `SEE_NEVER(a_pop_busy, i_clk, i_rst_n, o_pop && (r_busy || i_empty), "queue read while a run is open or nothing waits")

endmodule

/* rtl/string_escape_encoder.sv */
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_stall     i_in_byte, i_text_end
// output    o_out_valid / i_out_stall   o_out_byte, o_run_last, o_text_done
//
// Each input item yields one to four output bytes, one byte per cycle while i_out_stall is low.
// A plain byte yields one output byte, a named escape two and a hex escape four.
// The output register sets the pace; a short queue decouples input from output.
// An accepted item is first stored in the queue; its first byte is then registered in the output register.
// Reset is synchronous and clears the queue and the output valid flag.
// Input stall rises only while the queue is full.
module string_escape_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_text_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_text_done
);
    import see_pkg::*;

    localparam int RUN_W = $bits(t_run);

    t_run             push_run;
    t_run             head_run;
    logic [RUN_W-1:0] head_bits;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    see_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_text_end (i_text_end),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_run      (push_run),
        .i_full     (full)
    );

    see_fifo #(
        .WIDTH (RUN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_run),
        .o_full      (full),
        .i_pop       (pop),
        .o_head      (head_bits),
        .o_empty     (empty)
    );

    assign head_run = t_run'(head_bits);

    see_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_run),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_done (o_text_done)
    );

endmodule

/* dv/string_escape_encoder_tb.sv */
`timescale 1ns / 100ps

package escape_chars_pkg;

    localparam logic [7:0] BACKSLASH  = 8'h5C;
    localparam logic [7:0] QUOTE      = 8'h22;
    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam logic [7:0] RETURN_CH  = 8'h0D;
    localparam logic [7:0] TAB        = 8'h09;
    localparam logic [7:0] VTAB       = 8'h0B;
    localparam logic [7:0] FORMFEED   = 8'h0C;
    localparam logic [7:0] SPACE      = 8'h20;
    localparam logic [7:0] TILDE      = 8'h7E;
    localparam logic [7:0] LETTER_N   = 8'h6E;
    localparam logic [7:0] LETTER_R   = 8'h72;
    localparam logic [7:0] LETTER_T   = 8'h74;
    localparam logic [7:0] LETTER_V   = 8'h76;
    localparam logic [7:0] LETTER_F   = 8'h66;
    localparam logic [7:0] LETTER_X   = 8'h78;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] LETTER_A   = 8'h61;

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       text_done;
    } t_esc_byte;

endpackage

import escape_chars_pkg::*;

class escaped_byte_tracker;

    t_esc_byte pending_bytes[$];
    int        errors;
    int        text_bytes;
    int        text_ends;
    int        hex_escapes;
    int        escaped_bytes;

    function logic [7:0] hex_char(logic [3:0] nibble);
        if (nibble < 4'd10) begin
            return DIGIT_ZERO + 8'(nibble);
        end
        return LETTER_A + 8'(nibble) - 8'd10;
    endfunction

    function void note_text_byte(logic [7:0] text_byte, logic text_end);
        logic [7:0] run[$];
        t_esc_byte  eb;
        text_bytes++;
        if (text_end) begin
            text_ends++;
        end
        case (text_byte)
            QUOTE, BACKSLASH: run = '{BACKSLASH, text_byte};
            NEWLINE:          run = '{BACKSLASH, LETTER_N};
            RETURN_CH:        run = '{BACKSLASH, LETTER_R};
            TAB:              run = '{BACKSLASH, LETTER_T};
            VTAB:             run = '{BACKSLASH, LETTER_V};
            FORMFEED:         run = '{BACKSLASH, LETTER_F};
            default: begin
                if (text_byte < SPACE) begin
                    run = '{BACKSLASH, LETTER_X, hex_char(text_byte[7:4]),
                            hex_char(text_byte[3:0])};
                    hex_escapes++;
                end else begin
                    run = '{text_byte};
                end
            end
        endcase
        foreach (run[k]) begin
            eb.value     = run[k];
            eb.run_last  = (k == run.size() - 1);
            eb.text_done = (k == run.size() - 1) && text_end;
            pending_bytes.insert(pending_bytes.size(), eb);
        end
    endfunction

    function void check_escaped_byte(logic [7:0] value, logic run_last, logic text_done);
        t_esc_byte want;
        escaped_bytes++;
        if (pending_bytes.size() == 0) begin
            $error("unexpected output byte 0x%02h with no item outstanding", value);
            errors++;
            return;
        end
        want = pending_bytes.pop_front();
        if (value !== want.value) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.value, value);
            errors++;
        end
        if (run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, run_last);
            errors++;
        end
        if (text_done !== want.text_done) begin
            $error("text_done: expected %0b, got %0b", want.text_done, text_done);
            errors++;
        end
    endfunction

    function int pending_count();
        return pending_bytes.size();
    endfunction

endclass

module string_escape_encoder_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 300;
    localparam int CALM_ITEMS   = 60;
    localparam int TAIL_CYCLES  = 20;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       i_text_end;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_text_done;

    escaped_byte_tracker tracker = new();
    bit                  calm;
    int                  cycle_count = 0;

    logic [7:0] directed_text[$] = '{8'h00, 8'h1F, 8'h20, 8'h7F, 8'h80, 8'hFF, QUOTE,
                                     BACKSLASH, NEWLINE, RETURN_CH, TAB, VTAB, FORMFEED,
                                     8'h01, 8'h0F, 8'h10, 8'h1A, 8'h41, TILDE, 8'h0E,
                                     8'h55};
    logic       directed_end[$]  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                     1'b1};

    string_escape_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_text_end  (i_text_end),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_done (o_text_done)
    );

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_escaped_byte(o_out_byte, o_run_last, o_text_done);
        end
    end

    task automatic send_item(input logic [7:0] text_byte, input logic text_end);
        i_in_valid <= 1'b1;
        i_in_byte  <= text_byte;
        i_text_end <= text_end;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_text_byte(text_byte, text_end);
        @(negedge i_clk);
    endtask

    task automatic idle_input(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_output();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (tracker.pending_count() != 0);
    endtask

    function automatic logic [7:0] random_text_byte();
        logic [7:0] specials[7] = '{QUOTE, BACKSLASH, NEWLINE, RETURN_CH, TAB, VTAB,
                                    FORMFEED};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(SPACE, TILDE));
            4, 5:       return 8'($urandom_range(0, SPACE - 1));
            6:          return specials[$urandom_range(0, 6)];
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        i_out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(negedge i_clk);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timed out with %0d bytes outstanding.", tracker.pending_count());
        $display("** string_escape_encoder: FAILED **");
        $finish;
    end

    initial begin
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'h00;
        i_text_end  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_text[k]) begin
            send_item(directed_text[k], directed_end[k]);
        end
        drain_output();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - CALM_ITEMS) begin
                calm = 1'b1;
            end
            if (k == RANDOM_ITEMS / 2) begin
                drain_output();
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
                idle_input($urandom_range(1, 14));
            end
            send_item(random_text_byte(), $urandom_range(0, 7) == 0);
        end

        drain_output();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d text items (%0d text ends, %0d hex escapes); checked %0d bytes.",
                 tracker.text_bytes, tracker.text_ends, tracker.hex_escapes,
                 tracker.escaped_bytes);
        if (tracker.errors == 0 && tracker.pending_count() == 0) begin
            $display("** string_escape_encoder: PASSED **");
        end else begin
            $display("** string_escape_encoder: FAILED **");
        end
        $finish;
    end

endmodule
